// ===== rtl/acm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the Apostolico-Crochemore matcher.
// No dependencies.
package acm_pkg;
    localparam int MAX_PATTERN = 64;
    localparam int ADDR_W      = $clog2(MAX_PATTERN);
    localparam int IDX_W       = $clog2(MAX_PATTERN + 1);
    localparam int POS_W       = 16;

    typedef enum logic {
        CMD_PATTERN = 1'b0,
        CMD_TEXT    = 1'b1
    } cmd_t;
endpackage

// ===== rtl/acm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module acm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/apostolico_crochemore_matcher_core.sv =====
`timescale 1ns / 1ps
// Apostolico-Crochemore matcher: load/build sequencer and lazy text scan.
// Depends on acm_pkg and acm_ram.
//
// Usage: one input channel (s_valid/s_ready) carries pattern bytes (s_cmd=0)
// and text bytes (s_cmd=1); s_last marks the end of the pattern or the text.
// A pattern beat gives no result; the beat marked last starts the failure-table
// build, during which s_ready is low. Each text beat gives exactly one result
// beat on m_valid/m_ready: m_found and the window start in m_position (modulo
// 2^16). A text beat is taken in, scanned by character comparisons and window
// shifts, its scan closed and its result handed over to the output register
// (before a pattern is loaded it goes straight to the hand-over); s_ready stays
// low meanwhile, so no new beat is taken before that. The scan costs amortised
// close to 2 comparisons per byte. The pattern, failure table and text ring
// live in three RAMs, read one entry per cycle each. Reset (aresetn low,
// synchronous) drops any pattern; text sent before a pattern is loaded gives
// found=0, position=0. The output is one register: while the receiver stalls,
// the next beat is still taken in and worked on, and its result waits until
// the register frees.
module apostolico_crochemore_matcher_core
    import acm_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_cmd,
    input  logic [7:0]       s_data,
    input  logic             s_last,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_found,
    output logic [POS_W-1:0] m_position
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_B_INIT, ST_B_LDA, ST_B_IN, ST_B_CMP, ST_B_STEP, ST_B_S2, ST_B_S3,
        ST_CMP, ST_CMP_EV, ST_K, ST_K_EV, ST_SHIFT, ST_SHIFT2, ST_OUT
    } state_t;

    state_t            state_reg;
    logic              loading_reg, ready_reg, run_open_reg, last_reg;
    logic [IDX_W-1:0]  len_reg, lead_reg, run_reg, i_reg, k_reg, a_reg, fill_reg;
    logic [7:0]        pat0_reg, pa_reg, pb_reg, fb_reg, b_reg, d_reg;
    logic [ADDR_W-1:0] head_reg;
    logic [POS_W-1:0]  ws_reg, tc_reg, pos_reg;
    logic              found_reg;
    logic              m_valid_reg, m_found_reg;
    logic [POS_W-1:0]  m_position_reg;

    // RAM ports
    logic              pat_we, ring_we, fail_we;
    logic [ADDR_W-1:0] pat_waddr, pat_raddr, ring_raddr, head_next;
    logic [IDX_W-1:0]  fail_waddr, fail_raddr;
    logic [7:0]        pat_rdata, ring_rdata, fail_rdata, fail_wdata;

    logic              accept;
    logic              out_load;
    logic [IDX_W-1:0]  load_idx, run_next, fill_next;
    logic              run_open_next;
    logic [7:0]        shift_w, d_diff;
    logic [POS_W-1:0]  t_diff;
    logic              i_lt_m, i_le_d, b_eq;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign load_idx = loading_reg ? len_reg : '0;
    assign head_next = head_reg + ADDR_W'(1);
    assign fill_next = (fill_reg < IDX_W'(MAX_PATTERN)) ? fill_reg + IDX_W'(1) : fill_reg;

    assign i_lt_m  = (i_reg < len_reg);
    assign i_le_d  = $signed({1'b0, i_reg}) <= $signed(d_reg);
    assign shift_w = {1'b0, i_reg} - fail_rdata;
    assign b_eq    = (a_reg < len_reg) && (pat_rdata == pb_reg);
    assign t_diff  = tc_reg - ws_reg;

    always_comb begin
        run_next      = run_reg;
        run_open_next = run_open_reg;
        if (load_idx == '0) begin
            run_next      = IDX_W'(1);
            run_open_next = 1'b1;
        end else if (load_idx < IDX_W'(MAX_PATTERN)) begin
            if (run_open_reg && s_data == pat0_reg) begin
                run_next = load_idx + IDX_W'(1);
            end else begin
                run_open_next = 1'b0;
            end
        end
    end

    always_comb begin
        pat_we    = accept && (s_cmd == CMD_PATTERN) && (load_idx < IDX_W'(MAX_PATTERN));
        pat_waddr = load_idx[ADDR_W-1:0];
        ring_we   = accept && (s_cmd == CMD_TEXT) && ready_reg;
        fail_we   = 1'b0;
        fail_waddr = a_reg;
        fail_wdata = b_eq ? fb_reg : b_reg;
        d_diff     = '0;
        pat_raddr  = a_reg[ADDR_W-1:0];
        fail_raddr = {1'b0, b_reg[ADDR_W-1:0]};
        ring_raddr = head_reg;
        unique case (state_reg)
            ST_B_INIT: begin
                fail_we    = 1'b1;
                fail_waddr = '0;
                fail_wdata = 8'hFF;
                pat_raddr  = '0;
            end
            ST_B_IN, ST_B_STEP: pat_raddr = b_reg[ADDR_W-1:0];
            ST_B_S3:   fail_we = 1'b1;
            ST_CMP: begin
                pat_raddr  = i_reg[ADDR_W-1:0];
                d_diff     = d_reg - {1'b0, i_reg};
                ring_raddr = head_reg - d_diff[ADDR_W-1:0];
            end
            ST_K: begin
                pat_raddr  = k_reg[ADDR_W-1:0];
                d_diff     = d_reg - {1'b0, k_reg};
                ring_raddr = head_reg - d_diff[ADDR_W-1:0];
            end
            ST_SHIFT:  fail_raddr = i_reg;
            default: ;
        endcase
    end

    acm_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_pat (
        .aclk(aclk), .we(pat_we), .waddr(pat_waddr), .wdata(s_data),
        .raddr(pat_raddr), .rdata(pat_rdata)
    );
    acm_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN + 1)) u_fail (
        .aclk(aclk), .we(fail_we), .waddr(fail_waddr), .wdata(fail_wdata),
        .raddr(fail_raddr), .rdata(fail_rdata)
    );
    acm_ram #(.WIDTH(8), .DEPTH(MAX_PATTERN)) u_ring (
        .aclk(aclk), .we(ring_we), .waddr(head_next), .wdata(s_data),
        .raddr(ring_raddr), .rdata(ring_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            loading_reg  <= 1'b0;
            ready_reg    <= 1'b0;
            run_open_reg <= 1'b0;
            len_reg      <= '0;
            lead_reg     <= '0;
            run_reg      <= '0;
            i_reg        <= '0;
            k_reg        <= '0;
            fill_reg     <= '0;
            head_reg     <= '0;
            ws_reg       <= '0;
            tc_reg       <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept && s_cmd == CMD_PATTERN) begin
                        loading_reg  <= !s_last;
                        run_reg      <= run_next;
                        run_open_reg <= run_open_next;
                        if (load_idx == '0) begin
                            pat0_reg <= s_data;
                        end
                        len_reg <= (load_idx < IDX_W'(MAX_PATTERN))
                                   ? load_idx + IDX_W'(1) : load_idx;
                        ready_reg <= s_last;
                        if (s_last) begin
                            lead_reg  <= (run_next >= ((load_idx < IDX_W'(MAX_PATTERN))
                                          ? load_idx + IDX_W'(1) : load_idx))
                                         ? '0 : run_next;
                            i_reg     <= (run_next >= ((load_idx < IDX_W'(MAX_PATTERN))
                                          ? load_idx + IDX_W'(1) : load_idx))
                                         ? '0 : run_next;
                            k_reg     <= '0;
                            tc_reg    <= '0;
                            ws_reg    <= '0;
                            fill_reg  <= '0;
                            state_reg <= ST_B_INIT;
                        end
                    end else if (accept) begin
                        found_reg <= 1'b0;
                        last_reg  <= s_last;
                        if (ready_reg) begin
                            head_reg <= head_next;
                            fill_reg <= fill_next;
                            if (fill_next >= len_reg) begin
                                pos_reg <= tc_reg - {{(POS_W-IDX_W){1'b0}}, len_reg}
                                           + POS_W'(1);
                            end else begin
                                pos_reg <= '0;
                            end
                            if (t_diff > {{(POS_W-IDX_W){1'b0}}, len_reg - IDX_W'(1)}) begin
                                d_reg <= {1'b0, len_reg - IDX_W'(1)};
                            end else begin
                                d_reg <= t_diff[7:0];
                            end
                            state_reg <= ST_CMP;
                        end else begin
                            pos_reg   <= '0;
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_B_INIT: begin
                    a_reg     <= '0;
                    b_reg     <= 8'hFF;
                    state_reg <= ST_B_LDA;
                end
                ST_B_LDA: begin
                    pa_reg    <= pat_rdata;
                    state_reg <= ST_B_IN;
                end
                ST_B_IN: begin
                    if (b_reg[7]) begin
                        a_reg     <= a_reg + IDX_W'(1);
                        b_reg     <= b_reg + 8'd1;
                        state_reg <= ST_B_STEP;
                    end else begin
                        state_reg <= ST_B_CMP;
                    end
                end
                ST_B_CMP: begin
                    if (pa_reg != pat_rdata) begin
                        b_reg     <= fail_rdata;
                        state_reg <= ST_B_IN;
                    end else begin
                        a_reg     <= a_reg + IDX_W'(1);
                        b_reg     <= b_reg + 8'd1;
                        state_reg <= ST_B_STEP;
                    end
                end
                ST_B_STEP: state_reg <= ST_B_S2;
                ST_B_S2: begin
                    pb_reg    <= pat_rdata;
                    fb_reg    <= fail_rdata;
                    state_reg <= ST_B_S3;
                end
                ST_B_S3: begin
                    pa_reg    <= pat_rdata;
                    state_reg <= (a_reg < len_reg) ? ST_B_IN : ST_IDLE;
                end
                ST_CMP: begin
                    if (i_lt_m && i_le_d) begin
                        state_reg <= ST_CMP_EV;
                    end else if (i_lt_m) begin
                        if (last_reg) begin
                            tc_reg   <= '0;
                            ws_reg   <= '0;
                            fill_reg <= '0;
                            i_reg    <= lead_reg;
                            k_reg    <= '0;
                        end else begin
                            tc_reg   <= tc_reg + POS_W'(1);
                        end
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_K;
                    end
                end
                ST_CMP_EV: begin
                    if (pat_rdata == ring_rdata) begin
                        i_reg     <= i_reg + IDX_W'(1);
                        state_reg <= ST_CMP;
                    end else begin
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_K: begin
                    if (k_reg < lead_reg) begin
                        state_reg <= ST_K_EV;
                    end else begin
                        found_reg <= 1'b1;
                        pos_reg   <= ws_reg;
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_K_EV: begin
                    if (pat_rdata == ring_rdata) begin
                        k_reg     <= k_reg + IDX_W'(1);
                        state_reg <= ST_K;
                    end else begin
                        state_reg <= ST_SHIFT;
                    end
                end
                ST_SHIFT: state_reg <= ST_SHIFT2;
                ST_SHIFT2: begin
                    ws_reg <= ws_reg + {{(POS_W-8){1'b0}}, shift_w};
                    d_reg  <= d_reg - shift_w;
                    if (i_reg == lead_reg) begin
                        k_reg <= (k_reg != '0) ? k_reg - IDX_W'(1) : '0;
                    end else if ($signed(fail_rdata) <= $signed({1'b0, lead_reg})) begin
                        k_reg <= ($signed(fail_rdata) > 0) ? fail_rdata[IDX_W-1:0] : '0;
                        i_reg <= lead_reg;
                    end else begin
                        k_reg <= lead_reg;
                        i_reg <= fail_rdata[IDX_W-1:0];
                    end
                    state_reg <= ST_CMP;
                end
                ST_OUT: begin
                    if (out_load) begin
                        m_found_reg    <= found_reg;
                        m_position_reg <= pos_reg;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_position = m_position_reg;

    a_shift_back: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SHIFT2 |-> $signed(fail_rdata) < $signed({1'b0, i_reg}))
        else $error("failure entry not below scan index");
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && ready_reg) |-> i_reg <= len_reg)
        else $error("scan index beyond pattern length");
    a_prefix_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && ready_reg) |-> k_reg <= lead_reg)
        else $error("prefix index beyond leading run");
    a_found_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_found_reg) |-> len_reg != '0)
        else $error("match reported with no pattern");
endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for apostolico_crochemore_matcher_core: an in-bench match predictor,
// bursty pattern/text sender, stalling receiver. Depends on acm_pkg and the core RTL.
module tb_top
    import acm_pkg::*;
();

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } match_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_cmd;
    logic [7:0]       s_data;
    logic             s_last;
    logic             m_valid;
    logic             m_ready;
    logic             m_found;
    logic [POS_W-1:0] m_position;

    apostolico_crochemore_matcher_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd), .s_data(s_data),
        .s_last(s_last), .m_valid(m_valid), .m_ready(m_ready),
        .m_found(m_found), .m_position(m_position)
    );

    // predictor state
    int               pat_mem [MAX_PATTERN];
    int               fail_tab [MAX_PATTERN + 1];
    int               ring [MAX_PATTERN];
    int               plen, lead_run, scan_i, pref_k, ring_head, fill;
    logic [15:0]      win_start, txt_count;
    bit               loading, have_pat;

    match_t           expected_matches [$];
    int               mismatches;
    int               beats_sent;
    int               burst_left;
    bit               no_idle;
    bit               rx_free;
    int               rx_phase, rx_period, rx_duty;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #100_000_000;
        $display("tb_top: errors");
        $finish;
    end

    function automatic int pat(int q);
        if (q < 0 || q >= plen) return 256;
        return pat_mem[q];
    endfunction

    function automatic int text_at(int d, int q);
        return ring[(ring_head + MAX_PATTERN - (d - q)) % MAX_PATTERN];
    endfunction

    function automatic void restart_text();
        txt_count = '0;
        win_start = '0;
        fill      = 0;
        scan_i    = lead_run;
        pref_k    = 0;
    endfunction

    function automatic void build_failure();
        int a, b, e;
        a = 0;
        b = -1;
        fail_tab[0] = -1;
        while (a < plen) begin
            while (b > -1 && pat(a) != pat(b)) b = fail_tab[b];
            a++;
            b++;
            if (pat(a) == pat(b)) fail_tab[a] = fail_tab[b];
            else fail_tab[a] = b;
        end
        e = 1;
        while (e < plen && pat(e - 1) == pat(e)) e++;
        if (e >= plen) e = 0;
        lead_run = e;
    endfunction

    // returns 1 when the beat gives a result
    function automatic bit predict_match(logic c, logic [7:0] d8, logic l, output match_t r);
        int m, e, d, i, k, nx, s;
        logic [15:0] t;
        r = '0;
        if (c == CMD_PATTERN) begin
            if (!loading) begin
                loading  = 1'b1;
                have_pat = 1'b0;
                plen     = 0;
            end
            if (plen < MAX_PATTERN) begin
                pat_mem[plen] = d8;
                plen++;
            end
            if (l) begin
                loading = 1'b0;
                build_failure();
                have_pat = 1'b1;
                restart_text();
            end
            return 1'b0;
        end
        if (!have_pat) return 1'b1;
        m = plen;
        e = lead_run;
        t = txt_count;
        ring_head = (ring_head + 1) % MAX_PATTERN;
        ring[ring_head] = d8;
        if (fill < MAX_PATTERN) fill++;
        if (fill >= m) r.position = t - 16'(m) + 16'd1;
        d = int'(16'(t - win_start));
        if (d > m - 1) d = m - 1;
        i = scan_i;
        k = pref_k;
        forever begin
            while (i < m && i <= d && pat(i) == text_at(d, i)) i++;
            if (i < m && i > d) break;
            if (i >= m) begin
                while (k < e && pat(k) == text_at(d, k)) k++;
                if (k >= e) begin
                    r.found    = 1'b1;
                    r.position = win_start;
                end
            end
            nx = fail_tab[i];
            s = i - nx;
            win_start = win_start + 16'(s);
            d -= s;
            if (i == e) begin
                k = (k > 0) ? k - 1 : 0;
            end else if (nx <= e) begin
                k = (nx > 0) ? nx : 0;
                i = e;
            end else begin
                k = e;
                i = nx;
            end
        end
        scan_i    = i;
        pref_k    = k;
        txt_count = t + 16'd1;
        if (l) restart_text();
        return 1'b1;
    endfunction

    task automatic send_beat(logic c, logic [7:0] d8, logic l);
        match_t r;
        if (!no_idle) begin
            if (burst_left == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge aclk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        s_valid <= 1'b1;
        s_cmd   <= c;
        s_data  <= d8;
        s_last  <= l;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        if (predict_match(c, d8, l, r)) expected_matches.push_back(r);
    endtask

    task automatic send_pattern(int n, logic [7:0] a, logic [7:0] b, int mode);
        for (int j = 0; j < n; j++) begin
            send_beat(CMD_PATTERN, (mode == 0 || $urandom_range(0, 2) != 0) ? a : b,
                      j == n - 1);
        end
    endtask

    // text mostly from the same two letters with an occasional random byte, pattern copies dropped in often
    task automatic send_text(int n, logic [7:0] a, logic [7:0] b, bit mark_last);
        int j, q, cp;
        j = 0;
        while (j < n) begin
            if ($urandom_range(0, 3) == 0 && plen > 0) begin
                for (q = 0; q < plen && j < n; q++, j++)
                    send_beat(CMD_TEXT, 8'(pat_mem[q]), mark_last && j == n - 1);
            end else begin
                cp = $urandom_range(0, 19);
                send_beat(CMD_TEXT, cp == 0 ? 8'($urandom) : (cp < 10 ? a : b),
                          mark_last && j == n - 1);
                j++;
            end
        end
    endtask

    task automatic test_directed();
        send_beat(CMD_TEXT, 8'h5A, 1'b0);
        send_beat(CMD_TEXT, 8'hA5, 1'b1);
        send_beat(CMD_PATTERN, 8'hFF, 1'b1);
        send_beat(CMD_TEXT, 8'hFF, 1'b0);
        send_beat(CMD_TEXT, 8'h00, 1'b0);
        send_beat(CMD_TEXT, 8'hFF, 1'b1);
        send_beat(CMD_PATTERN, 8'h00, 1'b0);
        send_beat(CMD_TEXT, 8'h00, 1'b0);
        send_beat(CMD_PATTERN, 8'h00, 1'b0);
        send_beat(CMD_PATTERN, 8'h01, 1'b1);
        foreach (pat_mem[j]) if (j < 7) send_beat(CMD_TEXT, j == 5 ? 8'h01 : 8'h00, j == 6);
        send_beat(CMD_PATTERN, 8'h80, 1'b0);
        send_beat(CMD_PATTERN, 8'h80, 1'b1);
        repeat (4) send_beat(CMD_TEXT, 8'h80, 1'b0);
    endtask

    task automatic test_random();
        logic [7:0] a, b;
        int n;
        while (beats_sent < 760) begin
            no_idle = ($urandom_range(0, 5) == 0);
            a = 8'($urandom);
            b = 8'($urandom);
            case ($urandom_range(0, 19))
                0:       n = $urandom_range(64, 70);
                1:       n = $urandom_range(20, 63);
                default: n = $urandom_range(1, 8);
            endcase
            send_pattern(n, a, b, $urandom_range(0, 4) == 0 ? 0 : 1);
            if ($urandom_range(0, 9) == 0) begin
                send_pattern($urandom_range(1, 3), a, b, 1);
                send_beat(CMD_PATTERN, a, 1'b0);
                send_beat(CMD_TEXT, b, 1'b0);
                send_beat(CMD_PATTERN, b, 1'b1);
            end
            repeat ($urandom_range(1, 3))
                send_text(n > 20 ? $urandom_range(n, n + 30) : $urandom_range(3, 40),
                          a, b, $urandom_range(0, 3) != 0);
        end
        no_idle = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (rx_free) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= (rx_phase < rx_duty);
        end
        rx_phase <= (rx_phase + 1 >= rx_period) ? 0 : rx_phase + 1;
        if (rx_phase == 0 && $urandom_range(0, 7) == 0) begin
            rx_free   <= ($urandom_range(0, 2) == 0);
            rx_period <= $urandom_range(2, 9);
            rx_duty   <= $urandom_range(1, 8);
        end
    end

    always @(posedge aclk) begin
        match_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_matches.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: found=%0d position=%0d",
                             m_found, m_position);
            end else begin
                want = expected_matches.pop_front();
                if (m_found !== want.found || m_position !== want.position) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected found=%0d position=%0d, got %0d %0d",
                                 want.found, want.position, m_found, m_position);
                end
            end
        end
    end

    initial begin
        int waited;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_cmd      = 1'b0;
        s_data     = '0;
        s_last     = 1'b0;
        m_ready    = 1'b0;
        rx_free    = 1'b1;
        rx_phase   = 0;
        rx_period  = 4;
        rx_duty    = 2;
        mismatches = 0;
        beats_sent = 0;
        burst_left = 0;
        no_idle    = 1'b0;
        foreach (pat_mem[j]) pat_mem[j] = 0;
        foreach (ring[j]) ring[j] = 0;
        foreach (fail_tab[j]) fail_tab[j] = 0;
        plen = 0;
        lead_run = 0;
        ring_head = 0;
        loading = 1'b0;
        have_pat = 1'b0;
        restart_text();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random();
        s_valid <= 1'b0;

        waited = 0;
        while (expected_matches.size() != 0 && waited < 100000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (50) @(posedge aclk);
        if (mismatches == 0 && expected_matches.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/acm_pkg.sv
rtl/acm_ram.sv
rtl/apostolico_crochemore_matcher_core.sv
tb/tb_top.sv
